/* rtl/core/particle_table_integrator_top_assert.svh */
// Assertion macros for the particle table integrator
`ifndef PARTICLE_TABLE_INTEGRATOR_TOP_ASSERT_SVH
`define PARTICLE_TABLE_INTEGRATOR_TOP_ASSERT_SVH
// implication checked on every clock outside reset
`define PTI_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PTI_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/core/pti_pkg.sv */
// Shared types and constants for the particle table integrator
package pti_pkg;
  localparam int SLOTS_DEF = 64;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] K_ADDED = 3'd0;
  localparam logic [2:0] K_DROPPED = 3'd1;
  localparam logic [2:0] K_CLEARED = 3'd2;
  localparam logic [2:0] K_PART = 3'd3;
  localparam logic [2:0] K_NONE = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [15:0] start_angle;
    logic [31:0] rotation_rate;
    logic [31:0] gravity_x;
    logic [31:0] gravity_y;
    logic [16:0] friction;
    logic [31:0] life_limit;
    logic [15:0] dt;
  } cmd_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [15:0] hd;
    logic [31:0] spin;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [16:0] drag;
    logic [31:0] lim;
    logic [31:0] age;
  } part_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fffffff;
    else if (v < -64'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

/* rtl/core/pti_front.sv */
// Front end: accept commands and queue them for the engine; CMD_UNUSED is dropped
module pti_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pti_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output pti_pkg::cmd_t q_cmd
);
  import pti_pkg::*;
  localparam int AW = $clog2(DEPTH);
  cmd_t buf_q [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != (AW+1)'(DEPTH));
  assign push = in_valid && in_ready && (in_cmd.command != CMD_UNUSED);
  assign q_valid = (cnt != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = buf_q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        buf_q[wp] <= in_cmd;
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

/* rtl/core/pti_engine.sv */
// Back end: particle table, integrator and result output
module pti_engine #(
  parameter int SLOTS = pti_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  pti_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    kind,
  output logic [31:0]   out_pos_x,
  output logic [31:0]   out_pos_y,
  output logic [15:0]   out_angle,
  output logic [31:0]   out_age,
  output logic          last
);
  import pti_pkg::*;
  `include "particle_table_integrator_top_assert.svh"
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_S1, S_S2, S_S3, S_S4, S_WB, S_SCAN, S_SRD, S_EMIT, S_WAIT
  } st_t;

  st_t st;
  part_t mem [SLOTS];
  part_t p;
  logic [CW-1:0] live, keep, idx;
  logic [15:0] dt;
  logic [31:0] vx, vy;
  logic signed [63:0] m0, m1, m2;
  logic [32:0] age_s;

  assign q_ready = (st == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      live <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != S_EMIT) out_valid <= 1'b0;
      case (st)
        S_IDLE: if (q_valid && !out_valid) begin
          out_pos_x <= '0; out_pos_y <= '0; out_angle <= '0; out_age <= '0;
          last <= 1'b1;
          case (q_cmd.command)
            CMD_ADD: begin
              out_valid <= 1'b1;
              if (live == CW'(SLOTS)) kind <= K_DROPPED;
              else begin
                kind <= K_ADDED;
                mem[live[AW-1:0]] <= '{q_cmd.pos_x, q_cmd.pos_y, q_cmd.vel_x,
                  q_cmd.vel_y, q_cmd.start_angle, q_cmd.rotation_rate,
                  q_cmd.gravity_x, q_cmd.gravity_y, q_cmd.friction,
                  q_cmd.life_limit, 32'd0};
                live <= live + 1'b1;
              end
            end
            CMD_CLEAR: begin
              out_valid <= 1'b1;
              kind <= K_CLEARED;
              live <= '0;
            end
            default: begin
              dt <= q_cmd.dt;
              idx <= '0;
              keep <= '0;
              st <= S_RD;
            end
          endcase
        end
        S_RD: begin
          if (idx == live) begin
            live <= keep;
            idx <= '0;
            st <= S_SCAN;
          end else begin
            p <= mem[idx[AW-1:0]];
            st <= S_S1;
          end
        end
        S_S1: begin
          age_s <= {1'b0, p.age} + 33'(dt);
          m0 <= $signed(p.spin) * $signed({1'b0, dt});
          m1 <= $signed(p.ax) * $signed({1'b0, dt});
          m2 <= $signed(p.ay) * $signed({1'b0, dt});
          st <= S_S2;
        end
        S_S2: begin
          p.age <= age_s[32] ? 32'hffffffff : age_s[31:0];
          p.hd <= p.hd + m0[47:32];
          vx <= sat32(64'($signed(p.vx)) + (m1 >>> 16));
          vy <= sat32(64'($signed(p.vy)) + (m2 >>> 16));
          st <= S_S3;
        end
        S_S3: begin
          if (p.drag != '0) begin
            m1 <= $signed(vx) * $signed({1'b0, p.drag});
            m2 <= $signed(vy) * $signed({1'b0, p.drag});
            st <= S_S4;
          end else begin
            p.vx <= vx; p.vy <= vy;
            m1 <= $signed(vx) * $signed({1'b0, dt});
            m2 <= $signed(vy) * $signed({1'b0, dt});
            st <= S_WB;
          end
        end
        S_S4: begin
          p.vx <= sat32(m1 >>> 16);
          p.vy <= sat32(m2 >>> 16);
          vx <= sat32(m1 >>> 16);
          vy <= sat32(m2 >>> 16);
          m1 <= $signed(sat32(m1 >>> 16)) * $signed({1'b0, dt});
          m2 <= $signed(sat32(m2 >>> 16)) * $signed({1'b0, dt});
          st <= S_WB;
        end
        S_WB: begin
          if (p.age <= p.lim) begin
            mem[keep[AW-1:0]] <= '{sat32(64'($signed(p.x)) + (m1 >>> 16)),
              sat32(64'($signed(p.y)) + (m2 >>> 16)), p.vx, p.vy, p.hd,
              p.spin, p.ax, p.ay, p.drag, p.lim, p.age};
            keep <= keep + 1'b1;
          end
          idx <= idx + 1'b1;
          st <= S_RD;
        end
        S_SCAN: begin
          if (live == '0) begin
            out_valid <= 1'b1;
            kind <= K_NONE;
            out_pos_x <= '0; out_pos_y <= '0; out_angle <= '0; out_age <= '0;
            last <= 1'b1;
            st <= S_IDLE;
          end else begin
            p <= mem[idx[AW-1:0]];
            st <= S_EMIT;
          end
        end
        S_EMIT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          kind <= K_PART;
          out_pos_x <= p.x; out_pos_y <= p.y; out_angle <= p.hd; out_age <= p.age;
          last <= (idx + 1'b1 == live);
          idx <= idx + 1'b1;
          st <= (idx + 1'b1 == live) ? S_IDLE : S_SRD;
        end
        S_SRD: begin
          p <= mem[idx[AW-1:0]];
          st <= S_EMIT;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `PTI_ASSERT_IMP(a_live_bound, 1'b1, live <= CW'(SLOTS))
  `PTI_ASSERT_IMP(a_keep_le_idx, st == S_RD, keep <= idx)
  `PTI_ASSERT_NEXT(a_add_grows, q_valid && q_ready && q_cmd.command == CMD_ADD
    && live != CW'(SLOTS), live == $past(live) + 1'b1)
endmodule

/* rtl/core/particle_table_integrator_top.sv */
// Top level of the particle table integrator
// Commands enter a two-entry queue; an add or clear result is registered at the
// engine output as the engine takes the command from the queue, and the engine
// takes the next command the cycle after that result leaves. A tick walks the
// table one particle at a time through a shared multiply path (read, scale by
// dt, update, friction when set, write back), then reads each survivor back
// from the table and emits it, waiting while the receiver is not ready.
module particle_table_integrator_top #(
  parameter int SLOTS = pti_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [15:0] start_angle,
  input  logic [31:0] rotation_rate,
  input  logic [31:0] gravity_x,
  input  logic [31:0] gravity_y,
  input  logic [16:0] friction,
  input  logic [31:0] life_limit,
  input  logic [15:0] dt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [15:0] out_angle,
  output logic [31:0] out_age,
  output logic        last
);
  import pti_pkg::*;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{command, pos_x, pos_y, vel_x, vel_y, start_angle, rotation_rate,
    gravity_x, gravity_y, friction, life_limit, dt};

  pti_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd, .q_valid, .q_ready, .q_cmd
  );

  pti_engine #(.SLOTS(SLOTS)) u_engine (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .kind, .out_pos_x, .out_pos_y, .out_angle, .out_age, .last
  );
endmodule
